[rtl/sis_pkg.sv]
package sis_pkg;

  localparam int COORD_BITS = 16;
  localparam int COEF_BITS  = 48;
  localparam int COUNT_BITS = 16;
  localparam int THR_BITS   = 32;
  localparam int NCOEF      = 8;
  localparam int IDX_BITS   = $clog2(NCOEF);

  localparam int COORD_FRAC = 4;
  localparam int COEF_FRAC  = 40;
  localparam int THR_FRAC   = 16;
  localparam int LHS_SHIFT  = THR_FRAC - 2 * COORD_FRAC;

  localparam logic [THR_BITS-1:0]   THR_RESET = THR_BITS'(1) << THR_FRAC;
  localparam logic [COEF_BITS-1:0]  COEF_ONE  = COEF_BITS'(1) << COEF_FRAC;
  localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1) << COORD_FRAC;

  // epipolar line terms, residual, denominator, wide product
  localparam int AW = COEF_BITS + COORD_BITS + 2;
  localparam int NW = AW + COORD_BITS + 2;
  localparam int DW = 2 * AW + 1;
  localparam int LW = 2 * NW + LHS_SHIFT;
  localparam int BW = NW;

  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  localparam int UOP_LAST = 23;
  localparam int UOP_BITS = $clog2(UOP_LAST + 1);

  typedef enum logic {OP_LOAD, OP_SCORE} op_t;

  typedef struct packed {
    op_t                          op;
    logic [IDX_BITS-1:0]          idx;
    logic signed [COEF_BITS-1:0]  val;
    logic [COORD_BITS-1:0]        xl;
    logic [COORD_BITS-1:0]        yl;
    logic [COORD_BITS-1:0]        xr;
    logic [COORD_BITS-1:0]        yr;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {BK_IDLE, BK_LOAD, BK_RUN, BK_EMIT} back_state_t;

  typedef enum logic [4:0] {
    A_F0, A_F1, A_F2, A_F3, A_F4, A_F5, A_F6, A_F7, A_ONE,
    A_A0, A_A1, A_A2, A_ABS_A0, A_ABS_A1, A_ABS_B0, A_ABS_B1, A_NUMSH, A_DEN
  } a_sel_t;

  typedef enum logic [3:0] {
    B_XL, B_YL, B_XR, B_YR, B_ONE,
    B_ABS_A0, B_ABS_A1, B_ABS_B0, B_ABS_B1, B_ABS_NUM, B_THR
  } b_sel_t;

  typedef enum logic [3:0] {
    D_NONE, D_A0, D_A1, D_A2, D_B0, D_B1, D_NUM, D_DEN, D_LHS
  } dst_t;

  typedef struct packed {
    logic   clr;
    a_sel_t asel;
    b_sel_t bsel;
    dst_t   dst;
  } uop_t;

  function automatic uop_t mk(input logic c, input a_sel_t a, input b_sel_t b, input dst_t d);
    uop_t u;
    u.clr  = c;
    u.asel = a;
    u.bsel = b;
    u.dst  = d;
    return u;
  endfunction

  // multiply-accumulate program for one score item
  function automatic uop_t uop_rom(input logic [UOP_BITS-1:0] i);
    uop_t u;
    u = mk(1'b0, A_F0, B_XL, D_NONE);
    unique case (i)
      UOP_BITS'(0):  u = mk(1'b1, A_F0, B_XL, D_NONE);
      UOP_BITS'(1):  u = mk(1'b0, A_F1, B_YL, D_NONE);
      UOP_BITS'(2):  u = mk(1'b0, A_F2, B_ONE, D_A0);
      UOP_BITS'(3):  u = mk(1'b1, A_F3, B_XL, D_NONE);
      UOP_BITS'(4):  u = mk(1'b0, A_F4, B_YL, D_NONE);
      UOP_BITS'(5):  u = mk(1'b0, A_F5, B_ONE, D_A1);
      UOP_BITS'(6):  u = mk(1'b1, A_F6, B_XL, D_NONE);
      UOP_BITS'(7):  u = mk(1'b0, A_F7, B_YL, D_NONE);
      UOP_BITS'(8):  u = mk(1'b0, A_ONE, B_ONE, D_A2);
      UOP_BITS'(9):  u = mk(1'b1, A_F0, B_XR, D_NONE);
      UOP_BITS'(10): u = mk(1'b0, A_F3, B_YR, D_NONE);
      UOP_BITS'(11): u = mk(1'b0, A_F6, B_ONE, D_B0);
      UOP_BITS'(12): u = mk(1'b1, A_F1, B_XR, D_NONE);
      UOP_BITS'(13): u = mk(1'b0, A_F4, B_YR, D_NONE);
      UOP_BITS'(14): u = mk(1'b0, A_F7, B_ONE, D_B1);
      UOP_BITS'(15): u = mk(1'b1, A_A0, B_XR, D_NONE);
      UOP_BITS'(16): u = mk(1'b0, A_A1, B_YR, D_NONE);
      UOP_BITS'(17): u = mk(1'b0, A_A2, B_ONE, D_NUM);
      UOP_BITS'(18): u = mk(1'b1, A_ABS_A0, B_ABS_A0, D_NONE);
      UOP_BITS'(19): u = mk(1'b0, A_ABS_A1, B_ABS_A1, D_NONE);
      UOP_BITS'(20): u = mk(1'b0, A_ABS_B0, B_ABS_B0, D_NONE);
      UOP_BITS'(21): u = mk(1'b0, A_ABS_B1, B_ABS_B1, D_DEN);
      UOP_BITS'(22): u = mk(1'b1, A_NUMSH, B_ABS_NUM, D_LHS);
      UOP_BITS'(23): u = mk(1'b1, A_DEN, B_THR, D_NONE);
      default:       u = mk(1'b0, A_F0, B_XL, D_NONE);
    endcase
    return u;
  endfunction

endpackage

[rtl/sis_front.sv]
module sis_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_operation,
  input  logic [sis_pkg::IDX_BITS-1:0]   in_coef_index,
  input  logic signed [sis_pkg::COEF_BITS-1:0] in_coef_value,
  input  logic [sis_pkg::COORD_BITS-1:0] in_x_left,
  input  logic [sis_pkg::COORD_BITS-1:0] in_y_left,
  input  logic [sis_pkg::COORD_BITS-1:0] in_x_right,
  input  logic [sis_pkg::COORD_BITS-1:0] in_y_right,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sis_pkg::THR_BITS-1:0]   cfg_data,
  output logic [sis_pkg::THR_BITS-1:0]   thr,
  output sis_pkg::q_entry_t              entry
);
  import sis_pkg::*;

  logic [THR_BITS-1:0] thr_r;

  assign cfg_ready = 1'b1;
  assign thr       = thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // loads carry no coordinates, scores carry no coefficient
  always_comb begin
    entry.op = op_t'(in_operation);
    if (entry.op == OP_SCORE) begin
      entry.idx = '0;
      entry.val = '0;
      entry.xl  = in_x_left;
      entry.yl  = in_y_left;
      entry.xr  = in_x_right;
      entry.yr  = in_y_right;
    end else begin
      entry.idx = in_coef_index;
      entry.val = in_coef_value;
      entry.xl  = '0;
      entry.yl  = '0;
      entry.xr  = '0;
      entry.yr  = '0;
    end
  end

endmodule

[rtl/sis_queue.sv]
module sis_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sis_pkg::q_entry_t push_data,
  input  logic              pop,
  output sis_pkg::q_entry_t head,
  output sis_pkg::q_status_t status
);
  import sis_pkg::*;

  q_entry_t               mem_r [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r;
  logic [QPTR_BITS-1:0]   rd_ptr_r;
  logic [QPTR_BITS:0]     cnt_r;
  logic [QPTR_BITS:0]     cnt_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (cnt_r == (QPTR_BITS+1)'(QDEPTH));
  assign status.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/sis_back.sv]
module sis_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  sis_pkg::q_entry_t              head,
  input  logic [sis_pkg::THR_BITS-1:0]   thr,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_is_inlier,
  output logic [sis_pkg::COUNT_BITS-1:0] out_inlier_total
);
  import sis_pkg::*;

  back_state_t state_r, state_nxt;

  logic signed [COEF_BITS-1:0] coef_r [NCOEF];
  logic [COORD_BITS-1:0] xl_r, yl_r, xr_r, yr_r;
  logic [UOP_BITS-1:0]   uidx_r;
  logic signed [LW-1:0]  a_r, acc_r;
  logic [BW-1:0]         b_r;
  logic signed [AW-1:0]  a0_r, a1_r, a2_r, b0_r, b1_r;
  logic signed [NW-1:0]  num_r;
  logic [DW-1:0]         den_r;
  logic [LW-1:0]         lhs_r;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_inl_r;
  logic [COUNT_BITS-1:0] out_total_r;

  uop_t                  uop;
  logic                  last, b_zero, out_free, inl;
  logic                  coef_we, start, ld, step, store, emit;
  logic [AW-1:0]         abs_a0, abs_a1, abs_b0, abs_b1;
  logic [NW-1:0]         abs_num;
  logic signed [LW-1:0]  a_sel;
  logic [BW-1:0]         b_sel;

  assign uop      = uop_rom(uidx_r);
  assign last     = (uidx_r == UOP_BITS'(UOP_LAST));
  assign b_zero   = (b_r == '0);
  assign out_free = !out_valid_r || !out_stall;
  assign inl      = lhs_r < $unsigned(acc_r);

  assign abs_a0  = a0_r[AW-1] ? AW'(-a0_r) : AW'(a0_r);
  assign abs_a1  = a1_r[AW-1] ? AW'(-a1_r) : AW'(a1_r);
  assign abs_b0  = b0_r[AW-1] ? AW'(-b0_r) : AW'(b0_r);
  assign abs_b1  = b1_r[AW-1] ? AW'(-b1_r) : AW'(b1_r);
  assign abs_num = num_r[NW-1] ? NW'(-num_r) : NW'(num_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid && head.op == OP_SCORE) state_nxt = BK_LOAD;
      BK_LOAD: state_nxt = BK_RUN;
      BK_RUN:  if (b_zero) state_nxt = last ? BK_EMIT : BK_LOAD;
      BK_EMIT: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = (state_r == BK_IDLE) && q_valid;
    coef_we = q_pop && head.op == OP_LOAD;
    start   = q_pop && head.op == OP_SCORE;
    ld      = (state_r == BK_LOAD);
    step    = (state_r == BK_RUN) && !b_zero;
    store   = (state_r == BK_RUN) && b_zero;
    emit    = (state_r == BK_EMIT) && out_free;
  end

  always_comb begin
    unique case (uop.asel)
      A_F0:     a_sel = LW'(coef_r[0]);
      A_F1:     a_sel = LW'(coef_r[1]);
      A_F2:     a_sel = LW'(coef_r[2]);
      A_F3:     a_sel = LW'(coef_r[3]);
      A_F4:     a_sel = LW'(coef_r[4]);
      A_F5:     a_sel = LW'(coef_r[5]);
      A_F6:     a_sel = LW'(coef_r[6]);
      A_F7:     a_sel = LW'(coef_r[7]);
      A_ONE:    a_sel = signed'(LW'(COEF_ONE));
      A_A0:     a_sel = LW'(a0_r);
      A_A1:     a_sel = LW'(a1_r);
      A_A2:     a_sel = LW'(a2_r);
      A_ABS_A0: a_sel = signed'(LW'(abs_a0));
      A_ABS_A1: a_sel = signed'(LW'(abs_a1));
      A_ABS_B0: a_sel = signed'(LW'(abs_b0));
      A_ABS_B1: a_sel = signed'(LW'(abs_b1));
      A_NUMSH:  a_sel = signed'(LW'(abs_num) << LHS_SHIFT);
      A_DEN:    a_sel = signed'(LW'(den_r));
      default:  a_sel = '0;
    endcase
    unique case (uop.bsel)
      B_XL:      b_sel = BW'(xl_r);
      B_YL:      b_sel = BW'(yl_r);
      B_XR:      b_sel = BW'(xr_r);
      B_YR:      b_sel = BW'(yr_r);
      B_ONE:     b_sel = BW'(COORD_ONE);
      B_ABS_A0:  b_sel = BW'(abs_a0);
      B_ABS_A1:  b_sel = BW'(abs_a1);
      B_ABS_B0:  b_sel = BW'(abs_b0);
      B_ABS_B1:  b_sel = BW'(abs_b1);
      B_ABS_NUM: b_sel = BW'(abs_num);
      B_THR:     b_sel = BW'(thr);
      default:   b_sel = '0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (coef_we) cnt_nxt = '0;
    else if (emit && inl && cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
  end

  // datapath: serial shift-add multiply-accumulate
  always_ff @(posedge clk) begin
    if (coef_we) coef_r[head.idx] <= head.val;
    if (start) begin
      xl_r <= head.xl;
      yl_r <= head.yl;
      xr_r <= head.xr;
      yr_r <= head.yr;
    end
    if (ld) begin
      a_r <= a_sel;
      b_r <= b_sel;
      if (uop.clr) acc_r <= '0;
    end
    if (step) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= a_r <<< 1;
      b_r <= b_r >> 1;
    end
    if (store) begin
      unique case (uop.dst)
        D_A0:    a0_r  <= acc_r[AW-1:0];
        D_A1:    a1_r  <= acc_r[AW-1:0];
        D_A2:    a2_r  <= acc_r[AW-1:0];
        D_B0:    b0_r  <= acc_r[AW-1:0];
        D_B1:    b1_r  <= acc_r[AW-1:0];
        D_NUM:   num_r <= acc_r[NW-1:0];
        D_DEN:   den_r <= acc_r[DW-1:0];
        D_LHS:   lhs_r <= acc_r;
        default: ;
      endcase
    end
    if (emit) begin
      out_inl_r   <= inl;
      out_total_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      uidx_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (start) uidx_r <= '0;
      else if (store && !last) uidx_r <= uidx_r + 1'b1;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_inlier    = out_inl_r;
  assign out_inlier_total = out_total_r;

endmodule

[rtl/sampson_inlier_scorer_unit.sv]
// Sampson-error inlier scorer for one fundamental-matrix hypothesis. Load
// items write one of F00..F21 (F22 is one) and clear the inlier count; score
// items return the inlier flag and the saturating inlier count. A two-entry
// queue sits between the input stage and the arithmetic back end, so input
// is taken while a pair is being scored. The back end uses one serial
// shift-add multiply-accumulate unit: a score item is popped, then runs
// 24 passes (operand setup, one shift-add step per significant bit of the
// multiplier operand, write-back), then an emit that waits out any output
// stall; a load item is popped and written in the idle state. Threshold is
// written via cfg_data.
module sampson_inlier_scorer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [sis_pkg::IDX_BITS-1:0]   in_coef_index,
  input  logic signed [sis_pkg::COEF_BITS-1:0] in_coef_value,
  input  logic [sis_pkg::COORD_BITS-1:0] in_x_left,
  input  logic [sis_pkg::COORD_BITS-1:0] in_y_left,
  input  logic [sis_pkg::COORD_BITS-1:0] in_x_right,
  input  logic [sis_pkg::COORD_BITS-1:0] in_y_right,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_is_inlier,
  output logic [sis_pkg::COUNT_BITS-1:0] out_inlier_total,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sis_pkg::THR_BITS-1:0]   cfg_data
);
  import sis_pkg::*;

  q_entry_t            entry, head;
  q_status_t           q_stat;
  logic [THR_BITS-1:0] thr;
  logic                q_pop;

  assign in_stall = q_stat.full;

  sis_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_operation),
    .in_coef_index(in_coef_index),
    .in_coef_value(in_coef_value),
    .in_x_left    (in_x_left),
    .in_y_left    (in_y_left),
    .in_x_right   (in_x_right),
    .in_y_right   (in_y_right),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .thr          (thr),
    .entry        (entry)
  );

  sis_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid && !in_stall),
    .push_data(entry),
    .pop      (q_pop),
    .head     (head),
    .status   (q_stat)
  );

  sis_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (!q_stat.empty),
    .head            (head),
    .thr             (thr),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_inlier   (out_is_inlier),
    .out_inlier_total(out_inlier_total)
  );

`ifndef NO_ASSERTIONS
  a_empty_not_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !in_stall) else $error("stall with empty queue");

  a_inlier_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_inlier) |-> (out_inlier_total != '0))
    else $error("inlier with zero count");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("pop from empty queue");
`endif

endmodule
